// ===== sv/fdc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdc_pkg
// Shared constants and controller/datapath handshake types for the frame
// deframer with checksum.
// ----------------------------------------------------------------------------
package fdc_pkg;

  // Frame limits and storage geometry
  localparam int unsigned MAX_FRAME_LEN = 64;
  localparam int unsigned MIN_FRAME_LEN = 2;
  localparam int unsigned STORE_DEPTH   = MAX_FRAME_LEN;
  localparam int unsigned ADDR_W        = $clog2(STORE_DEPTH);
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned LEN_W         = 7;

  // Protocol bytes
  localparam logic [BYTE_W-1:0] START_BYTE = 8'h7E;
  localparam logic [BYTE_W-1:0] SUM_INIT   = 8'hFF;

  // Commands from controller to datapath
  typedef struct packed {
    logic len_hi_ld;   // latch length MSB
    logic frame_start; // latch length LSB, clear count and sum
    logic body_wr;     // store payload byte, update sum and count
    logic rd_start;    // clear readout index
    logic rd_issue;    // read store at readout index
    logic out_load;    // move read data to output register
  } fdc_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_start;    // received byte is the start byte
    logic len_ok;      // length in range
    logic body_done;   // this byte completes the payload
    logic sum_ok;      // checksum byte gives a zero sum
    logic rd_last;     // readout index points at last payload byte
    logic out_free;    // output register can take a byte
  } fdc_sts_t;

endpackage

// ===== sv/fdc_rx_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdc_rx_if
// Receive byte channel: valid/ready with one serial byte per transaction.
// ----------------------------------------------------------------------------
interface fdc_rx_if
  import fdc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== sv/fdc_pl_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdc_pl_if
// Payload channel: valid/ready with one payload byte of a good frame per
// transaction.
// ----------------------------------------------------------------------------
interface fdc_pl_if
  import fdc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] payload_byte;
  logic [LEN_W-1:0]  frame_length;
  logic              last_byte;

  modport source (output valid, output payload_byte, output frame_length,
                  output last_byte, input ready);
  modport sink   (input valid, input payload_byte, input frame_length,
                  input last_byte, output ready);
endinterface

// ===== sv/fdc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fdc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds when not reading
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/fdc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdc_ctrl
// Frame controller: hunts for the start byte, walks the length, body and
// checksum phases, then sequences readout of a good frame.
// ----------------------------------------------------------------------------
module fdc_ctrl
  import fdc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  fdc_sts_t sts_i,
  output fdc_cmd_t cmd_o
);

  localparam logic [2:0] ST_HUNT   = 3'd0;
  localparam logic [2:0] ST_LEN_HI = 3'd1;
  localparam logic [2:0] ST_LEN_LO = 3'd2;
  localparam logic [2:0] ST_BODY   = 3'd3;
  localparam logic [2:0] ST_CHECK  = 3'd4;
  localparam logic [2:0] ST_RD     = 3'd5;
  localparam logic [2:0] ST_LOAD   = 3'd6;

  logic [2:0] state_q, state_d;
  logic       in_ready;
  logic       in_fire;

  // Input is taken in every receive phase, held off during readout
  assign in_ready   = (state_q == ST_HUNT) || (state_q == ST_LEN_HI) ||
                      (state_q == ST_LEN_LO) || (state_q == ST_BODY) ||
                      (state_q == ST_CHECK);
  assign in_fire    = in_valid_i && in_ready;
  assign in_ready_o = in_ready;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_HUNT: begin
        if (in_fire && sts_i.is_start) begin
          state_d = ST_LEN_HI;
        end
      end
      ST_LEN_HI: begin
        if (in_fire && !sts_i.is_start) begin
          cmd_o.len_hi_ld = 1'b1;
          state_d         = ST_LEN_LO;
        end
      end
      ST_LEN_LO: begin
        if (in_fire) begin
          if (sts_i.len_ok) begin
            cmd_o.frame_start = 1'b1;
            state_d           = ST_BODY;
          end else if (sts_i.is_start) begin
            state_d = ST_LEN_HI;
          end else begin
            state_d = ST_HUNT;
          end
        end
      end
      ST_BODY: begin
        if (in_fire) begin
          cmd_o.body_wr = 1'b1;
          if (sts_i.body_done) begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (in_fire) begin
          if (sts_i.sum_ok) begin
            cmd_o.rd_start = 1'b1;
            state_d        = ST_RD;
          end else begin
            state_d = ST_HUNT;
          end
        end
      end
      ST_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = sts_i.rd_last ? ST_HUNT : ST_RD;
        end
      end
      default: begin
        state_d = ST_HUNT;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/fdc_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdc_dp
// Frame datapath: length registers, byte counter, running checksum, frame
// store and the output register.
// ----------------------------------------------------------------------------
module fdc_dp
  import fdc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [BYTE_W-1:0] rx_byte_i,
  input  fdc_cmd_t          cmd_i,
  output fdc_sts_t          sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] payload_byte_o,
  output logic [LEN_W-1:0]  frame_length_o,
  output logic              last_byte_o
);

  logic              hi_nz_q;
  logic [LEN_W-1:0]  exp_len_q;
  logic [LEN_W-1:0]  count_q;
  logic [LEN_W-1:0]  count_inc;
  logic [BYTE_W-1:0] sum_q;
  logic [BYTE_W-1:0] sum_next;
  logic [ADDR_W-1:0] rd_idx_q;
  logic [BYTE_W-1:0] rd_data;
  logic              out_valid_q;
  logic [BYTE_W-1:0] payload_q;
  logic [LEN_W-1:0]  len_q;
  logic              last_q;

  assign count_inc = count_q + LEN_W'(1);
  assign sum_next  = sum_q - rx_byte_i;

  // Status toward the controller
  assign sts_o.is_start  = (rx_byte_i == START_BYTE);
  assign sts_o.len_ok    = !hi_nz_q &&
                           (rx_byte_i >= BYTE_W'(MIN_FRAME_LEN)) &&
                           (rx_byte_i <= BYTE_W'(MAX_FRAME_LEN));
  assign sts_o.body_done = (count_inc == exp_len_q);
  assign sts_o.sum_ok    = (sum_next == '0);
  assign sts_o.rd_last   = (LEN_W'(rd_idx_q) == exp_len_q - LEN_W'(1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // Length registers; a nonzero MSB always means too long
  always_ff @(posedge clk_i) begin
    if (cmd_i.len_hi_ld) begin
      hi_nz_q <= (rx_byte_i != '0);
    end
    if (cmd_i.frame_start) begin
      exp_len_q <= rx_byte_i[LEN_W-1:0];
    end
  end

  // Byte counter and running checksum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= SUM_INIT;
    end else if (cmd_i.frame_start) begin
      count_q <= '0;
      sum_q   <= SUM_INIT;
    end else if (cmd_i.body_wr) begin
      count_q <= count_inc;
      sum_q   <= sum_next;
    end
  end

  // Readout index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q <= '0;
    end else if (cmd_i.rd_start) begin
      rd_idx_q <= '0;
    end else if (cmd_i.out_load) begin
      rd_idx_q <= rd_idx_q + ADDR_W'(1);
    end
  end

  // Frame store
  fdc_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.body_wr),
    .waddr_i(count_q[ADDR_W-1:0]),
    .wdata_i(rx_byte_i),
    .re_i   (cmd_i.rd_issue),
    .raddr_i(rd_idx_q),
    .rdata_o(rd_data)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      payload_q <= rd_data;
      len_q     <= exp_len_q;
      last_q    <= sts_o.rd_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign payload_byte_o = payload_q;
  assign frame_length_o = len_q;
  assign last_byte_o    = last_q;

endmodule

// ===== sv/api_frame_deframer_with_checksum_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// api_frame_deframer_with_checksum_top
// Start-delimiter / length / checksum frame receiver with payload readout.
//
//   Channel  Dir  Fields                                   Transaction
//   rx_i     in   rx_byte[7:0]                             one serial byte
//   pl_o     out  payload_byte[7:0], frame_length[6:0],    one payload byte
//                 last_byte                                of a good frame
//
// Each received byte is taken as soon as it is valid while a frame is being received.
// After a good checksum the stored payload is read out byte by byte, each byte
// by a store read, then an output register load; no byte is taken during
// readout, so input is held off until the last payload byte is loaded.
// Reset returns to hunting for the start byte; the frame store is not cleared.
// A stalled output holds its byte; the next byte is read from the store and
// then waits for its load until the held byte is taken.
// ----------------------------------------------------------------------------
module api_frame_deframer_with_checksum_top
  import fdc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  fdc_rx_if.sink    rx_i,
  fdc_pl_if.source  pl_o
);

  fdc_cmd_t cmd;
  fdc_sts_t sts;

  // Controller
  fdc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(rx_i.valid),
    .in_ready_o(rx_i.ready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // Datapath
  fdc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_byte_i     (rx_i.rx_byte),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (pl_o.valid),
    .out_ready_i   (pl_o.ready),
    .payload_byte_o(pl_o.payload_byte),
    .frame_length_o(pl_o.frame_length),
    .last_byte_o   (pl_o.last_byte)
  );

endmodule

// ===== sv/fdc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdc_checker
// Port-level checks for the frame deframer, bound to the top level.
// ----------------------------------------------------------------------------
module fdc_checker
  import fdc_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [BYTE_W-1:0] payload_byte_i,
  input logic [LEN_W-1:0]  frame_length_i,
  input logic              last_byte_i
);

  // Readout blocks input until the last byte is loaded
  a_no_rx_mid_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_byte_i |-> !in_ready_i)
    else $error("input taken while a frame is being emitted");

  // An input transaction never directly loads an output byte
  a_no_out_after_rx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i))
    else $error("output appeared right after an input transaction");

  // Emitted frame length stays within limits
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (frame_length_i >= LEN_W'(MIN_FRAME_LEN)) &&
                    (frame_length_i <= LEN_W'(MAX_FRAME_LEN)))
    else $error("frame length out of range");

  // A stalled output byte holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(payload_byte_i) &&
                                    $stable(last_byte_i))
    else $error("stalled output changed");

endmodule

bind api_frame_deframer_with_checksum_top fdc_checker u_fdc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (rx_i.valid),
  .in_ready_i    (rx_i.ready),
  .out_valid_i   (pl_o.valid),
  .out_ready_i   (pl_o.ready),
  .payload_byte_i(pl_o.payload_byte),
  .frame_length_i(pl_o.frame_length),
  .last_byte_i   (pl_o.last_byte)
);
